>>> rtl/assert_macros.svh
// Assertion macros, included by the top level for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> rtl/clrb_pkg.sv
// Types and constants of the command line receive buffer.
`default_nettype none

package clrb_pkg;

	// characters with a fixed meaning, and the comment depth limit
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_OPEN      = 8'h28;
	localparam logic [7:0] CH_CLOSE     = 8'h29;
	localparam logic [7:0] PRINT_LOW    = 8'h22;
	localparam logic [7:0] PRINT_HIGH   = 8'h7B;
	localparam logic [7:0] REPORT_RESET = 8'h3F;
	localparam logic [7:0] DEPTH_MAX    = 8'hFF;

	typedef enum logic [1:0] {
		ACT_RECV  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_RT   = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic take;    // input beat accepted this cycle
		logic finish;  // store read data is valid, complete the access
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic access;  // presented action is a read or a peek
	} ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/clrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module clrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/clrb_ctrl.sv
// Controller state machine: sequences accept, store read and result beat.
`default_nettype none

module clrb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire clrb_pkg::ctrl_sts_t sts,
	output clrb_pkg::ctrl_cmd_t     cmd
);
	import clrb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.access ? ST_RD : ST_OUT;
				end
			end
			ST_RD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshake and commands
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign cmd.take   = in_ready && in_valid;
	assign cmd.finish = (state_q == ST_RD);

endmodule

`default_nettype wire

>>> rtl/clrb_dp.sv
// Datapath: byte filter, ring buffer pointers, counters and result register.
`default_nettype none

module clrb_dp #(
	parameter int BUF_DEPTH = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [7:0]          cfg_wr_data,
	input  wire logic [1:0]          action,
	input  wire logic [7:0]          rx_byte,
	input  wire clrb_pkg::ctrl_cmd_t cmd,
	output clrb_pkg::ctrl_sts_t      sts,
	output logic [1:0]               result_kind,
	output logic [7:0]               out_byte,
	output logic [7:0]               lines_pending,
	output logic                     line_ready,
	output logic                     overflow
);
	import clrb_pkg::*;

	localparam int AW  = $clog2(BUF_DEPTH);
	localparam int CW  = $clog2(BUF_DEPTH + 1);
	localparam int LPW = (CW > 8) ? CW : 8;
	localparam logic [AW-1:0] PTR_LAST = AW'(BUF_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(BUF_DEPTH);

	action_t act;
	logic    peek_q;

	logic [7:0]    report_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] lines_q;
	logic [7:0]    depth_q;

	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       ovf_q;

	logic       is_rep, is_open, is_close, is_print, is_eol;
	logic       want_store, full, store_ok, ram_we;
	logic [7:0] ram_wdata, ram_rdata;
	logic       rd_hit;
	logic [LPW-1:0] lines_ext;

	assign act        = action_t'(action);
	assign sts.access = (act == ACT_READ) || (act == ACT_PEEK);

	// report character register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q <= REPORT_RESET;
		end else if (cfg_wr_en) begin
			report_q <= cfg_wr_data;
		end
	end

	// classify the received byte
	assign is_rep   = (rx_byte == report_q);
	assign is_open  = (rx_byte == CH_OPEN);
	assign is_close = (rx_byte == CH_CLOSE);
	assign is_print = (rx_byte > PRINT_LOW) && (rx_byte < PRINT_HIGH);
	assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	assign want_store = !is_rep && !is_open && !is_close &&
		((is_print && (depth_q == 8'd0)) || is_eol);
	assign full      = (occ_q == CNT_FULL);
	assign store_ok  = want_store && !full;
	assign ram_we    = cmd.take && (act == ACT_RECV) && store_ok;
	assign ram_wdata = is_eol ? CH_LF : rx_byte;

	clrb_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_ptr_q),
		.wr_data (ram_wdata),
		.rd_addr (rd_ptr_q),
		.rd_data (ram_rdata)
	);

	// a read or peek finds data only with a complete line pending
	assign rd_hit = (lines_q != '0) && (occ_q != '0);

	// pointers, counters and comment depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			occ_q    <= '0;
			lines_q  <= '0;
			depth_q  <= '0;
			peek_q   <= 1'b0;
		end else if (cmd.take) begin
			peek_q <= (act == ACT_PEEK);
			case (act)
				ACT_RECV: begin
					if (store_ok) begin
						wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
						occ_q    <= occ_q + 1'b1;
						if (is_eol) begin
							lines_q <= lines_q + 1'b1;
						end
					end
					if (!is_rep) begin
						if (is_open) begin
							if (depth_q != DEPTH_MAX) begin
								depth_q <= depth_q + 8'd1;
							end
						end else if (is_close) begin
							if (depth_q != 8'd0) begin
								depth_q <= depth_q - 8'd1;
							end
						end else if (!is_print && is_eol) begin
							depth_q <= '0;
						end
					end
				end
				ACT_CLEAR: begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
					occ_q    <= '0;
					lines_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.finish && rd_hit && !peek_q) begin
			rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			occ_q    <= occ_q - 1'b1;
			if (ram_rdata == CH_LF) begin
				lines_q <= lines_q - 1'b1;
			end
		end
	end

	// result register, held while the result beat waits
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ovf_q  <= (act == ACT_RECV) && want_store && full;
			kind_q <= KIND_NONE;
			byte_q <= '0;
			if ((act == ACT_RECV) &&
				(is_rep || !(is_open || is_close || is_print || is_eol))) begin
				kind_q <= KIND_RT;
				byte_q <= rx_byte;
			end
		end else if (cmd.finish && rd_hit) begin
			kind_q <= KIND_DATA;
			byte_q <= ram_rdata;
		end
	end

	assign lines_ext     = LPW'(lines_q);
	assign result_kind   = kind_q;
	assign out_byte      = byte_q;
	assign lines_pending = lines_ext[7:0];
	assign line_ready    = (lines_q != '0);
	assign overflow      = ovf_q;

endmodule

`default_nettype wire

>>> rtl/command_line_receive_buffer.sv
// Top level of the command line receive buffer: controller, datapath and checks.
// Each input beat carries an action: receive a byte, read or peek the next stored
// byte, or clear the buffer; each gives exactly one result beat. Receive and
// clear offer their result beat in the cycle after the input beat is taken; read
// and peek offer it after the store read state, which waits for the registered
// read port of the line store RAM. One item is in flight at a time, and the next
// input beat can be taken in the cycle after the result beat is taken. Write
// report_char only while idle.
`default_nettype none

`include "assert_macros.svh"

module command_line_receive_buffer #(
	parameter int BUF_DEPTH = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      result_kind,
	output logic [7:0]      out_byte,
	output logic [7:0]      lines_pending,
	output logic            line_ready,
	output logic            overflow
);
	import clrb_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	clrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	clrb_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.action        (action),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.result_kind   (result_kind),
		.out_byte      (out_byte),
		.lines_pending (lines_pending),
		.line_ready    (line_ready),
		.overflow      (overflow)
	);

	// checks
	`ASSERT_SAME(a_one_side, in_ready, !out_valid)
	`ASSERT_SAME(a_none_zero, out_valid && (result_kind == KIND_NONE), out_byte == 8'd0)
	`ASSERT_SAME(a_ovf_kind, out_valid && overflow, result_kind == KIND_NONE)
	`ASSERT_NEXT(a_back_idle, out_valid && out_ready, in_ready)

endmodule

`default_nettype wire
